[design/emb_pkg.sv]
// ----------------------------------------------------------------------------
// emb_pkg
// Shared types and constants of the extended memory block manager: beat
// payloads, segment table entry, sequencer states, call and status codes.
// ----------------------------------------------------------------------------
package emb_pkg;

  localparam int KB_W     = 22;
  localparam int HANDLE_W = 16;
  localparam int LOCK_W   = 8;

  localparam logic [KB_W-1:0] KB_MASK       = {KB_W{1'b1}};
  localparam int              MAX_SEGMENTS_DEF = 64;
  localparam logic [31:0]     POOL_BASE_DEF = 32'h0011_0000;
  localparam logic [KB_W-1:0] POOL_KB_RESET = 22'd15296;

  // configuration register indexes
  localparam logic CFG_POOL_KB = 1'b0;
  localparam logic CFG_A20     = 1'b1;

  // call codes
  localparam logic [4:0] OP_REQ_HMA     = 5'd0;
  localparam logic [4:0] OP_REL_HMA     = 5'd1;
  localparam logic [4:0] OP_GLOBAL_ON   = 5'd2;
  localparam logic [4:0] OP_GLOBAL_OFF  = 5'd3;
  localparam logic [4:0] OP_LOCAL_ON    = 5'd4;
  localparam logic [4:0] OP_LOCAL_OFF   = 5'd5;
  localparam logic [4:0] OP_QUERY_A20   = 5'd6;
  localparam logic [4:0] OP_QUERY_FREE  = 5'd7;
  localparam logic [4:0] OP_ALLOC       = 5'd8;
  localparam logic [4:0] OP_FREE        = 5'd9;
  localparam logic [4:0] OP_MOVE        = 5'd10;
  localparam logic [4:0] OP_LOCK        = 5'd11;
  localparam logic [4:0] OP_UNLOCK      = 5'd12;
  localparam logic [4:0] OP_INFO        = 5'd13;
  localparam logic [4:0] OP_REALLOC     = 5'd14;
  localparam logic [4:0] OP_REQ_UMB     = 5'd15;
  localparam logic [4:0] OP_REL_UMB     = 5'd16;
  localparam logic [4:0] OP_REALLOC_UMB = 5'd17;

  // status codes
  localparam logic [4:0] ST_OK         = 5'd0;
  localparam logic [4:0] ST_UNIMPL     = 5'd1;
  localparam logic [4:0] ST_A20_ERR    = 5'd2;
  localparam logic [4:0] ST_HMA_USED   = 5'd3;
  localparam logic [4:0] ST_HMA_FREE   = 5'd4;
  localparam logic [4:0] ST_A20_STILL  = 5'd5;
  localparam logic [4:0] ST_NO_MEM     = 5'd6;
  localparam logic [4:0] ST_NO_HANDLE  = 5'd7;
  localparam logic [4:0] ST_BAD_HANDLE = 5'd8;
  localparam logic [4:0] ST_LOCKED     = 5'd9;
  localparam logic [4:0] ST_BAD_SRC_H  = 5'd10;
  localparam logic [4:0] ST_BAD_SRC_O  = 5'd11;
  localparam logic [4:0] ST_BAD_DST_H  = 5'd12;
  localparam logic [4:0] ST_BAD_DST_O  = 5'd13;
  localparam logic [4:0] ST_BAD_LEN    = 5'd14;
  localparam logic [4:0] ST_OVERLAP    = 5'd15;
  localparam logic [4:0] ST_NOT_LOCKED = 5'd16;
  localparam logic [4:0] ST_LOCK_OVF   = 5'd17;
  localparam logic [4:0] ST_UMB_NA     = 5'd18;
  localparam logic [4:0] ST_UMB_BAD    = 5'd19;

  typedef struct packed {
    logic [4:0]          op;
    logic                wide;
    logic [HANDLE_W-1:0] handle;
    logic [KB_W-1:0]     size_kb;
    logic [31:0]         move_length;
    logic [HANDLE_W-1:0] src_handle;
    logic [31:0]         src_offset;
    logic [HANDLE_W-1:0] dst_handle;
    logic [31:0]         dst_offset;
  } in_t;

  typedef struct packed {
    logic                ok;
    logic [4:0]          status;
    logic [KB_W-1:0]     free_largest_kb;
    logic [KB_W-1:0]     free_total_kb;
    logic [HANDLE_W-1:0] handle_out;
    logic [31:0]         block_address;
    logic [LOCK_W-1:0]   lock_count;
    logic [HANDLE_W-1:0] handles_left;
    logic [KB_W-1:0]     block_size_kb;
    logic [31:0]         src_linear;
    logic [31:0]         dst_linear;
    logic                a20_on;
  } out_t;

  typedef struct packed {
    logic [KB_W-1:0]     offset;
    logic [KB_W-1:0]     size;
    logic [HANDLE_W-1:0] owner;
    logic [LOCK_W-1:0]   locks;
  } seg_t;

  localparam int SEG_W = $bits(seg_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_POST,
    S_MERGE,
    S_MFLUSH,
    S_SHUP,
    S_SHDN,
    S_WA,
    S_WB,
    S_MV,
    S_MV2,
    S_DONE
  } state_t;

endpackage

[design/emb_ram.sv]
// ----------------------------------------------------------------------------
// emb_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module emb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[design/extended_memory_block_manager.sv]
// ----------------------------------------------------------------------------
// extended_memory_block_manager
// Extended memory driver core: segment table, HMA and A20 bookkeeping.
//
// One call is taken at a time. A20 and HMA calls go from the execute
// state straight to completion. Calls on a handle walk the segment table
// at one entry per cycle through the single read port of the table RAM.
// An allocation or a shrink that splits a segment then shifts every entry
// above the split point up by one, and a free-space query is one pass of
// the table. An expanding realloc makes a merge pass, a second lookup pass
// and, when the next free segment is used up, a shift pass. The finished
// result sits in an output register, so the next call is taken while it
// waits. After reset or a pool size write the table is first reset to a
// single free segment holding the whole pool.
// ----------------------------------------------------------------------------
module extended_memory_block_manager import emb_pkg::*; #(
  parameter int          MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter logic [31:0] POOL_BASE    = POOL_BASE_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_t             in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_t            out_data,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [KB_W-1:0] cfg_data
);

  localparam int IDXW = $clog2(MAX_SEGMENTS);
  localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
  localparam int TOTW = KB_W + IDXW;
  localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_SEGMENTS);

  state_t state_r, state_nxt;

  in_t                 in_r;
  logic [KB_W-1:0]     req_r;
  out_t                res_r, out_data_r, fin;
  logic [4:0]          st_r;
  logic                okset_r, out_valid_r, ph_r;
  logic [CNTW-1:0]     used_r;
  logic [HANDLE_W-1:0] top_handle_r;
  logic                hma_r, a20g_r, a20l_r;
  logic [16:0]         a20cnt_r, cnt_dec;
  logic [KB_W-1:0]     cfg_pool_r;
  logic                init_pend_r;

  logic [CNTW-1:0]     rc_r, lim_r, rd_ptr;
  logic                dv_r, rd_issue, stream_fin;
  logic [IDXW-1:0]     di_r;

  logic                fa_r, fb_r, bf_r, nxt_v_r, grab_r;
  logic [IDXW-1:0]     fa_idx_r, bidx_r;
  seg_t                fa_ent_r, fb_ent_r, bent_r, nxt_ent_r;
  logic [HANDLE_W-1:0] top_r, key_a, newh, hl;

  seg_t                pend_r;
  logic [IDXW-1:0]     wp_r;
  logic [TOTW-1:0]     tot_r, tot_fin;
  logic [KB_W-1:0]     max_r, max_fin, pf_size, tot_clip, msat;
  logic [KB_W:0]       msum;
  logic                both_free;

  logic [IDXW-1:0]     wa_idx_r, wb_idx_r;
  seg_t                wa_ent_r, wb_ent_r;
  logic [31:0]         mv_sl_r, mv_dl_r;

  logic                ram_we;
  logic [IDXW-1:0]     ram_waddr, ram_raddr;
  logic [SEG_W-1:0]    ram_wdata, ram_rdata;
  seg_t                rd_ent, wr_ent;

  logic                exec_scan, alloc_split, grow_ok, ovl;
  logic [KB_W:0]       grow_sum;
  logic [KB_W-1:0]     grow_d;

  state_t              p_next;
  logic [4:0]          p_st, mv_st;
  out_t                p_res;
  logic [IDXW-1:0]     p_wa_idx, p_wb_idx;
  seg_t                p_wa_ent, p_wb_ent;
  logic [CNTW-1:0]     p_used, p_rc, p_lim;
  logic                p_top_we;
  logic [HANDLE_W-1:0] p_top;

  logic [31:0]         s_conv, d_conv, s_lin, d_lin, mv_sl, mv_dl;
  logic                s_bad, d_bad;

  emb_ram #(
    .WIDTH (SEG_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  function automatic logic [31:0] conv_addr(input logic [31:0] v, input logic line);
    logic [31:0] a;
    a = {12'b0, v[31:16], 4'b0} + {16'b0, v[15:0]};
    if (!line) begin
      a = a & 32'h000F_FFFF;
    end
    return a;
  endfunction

  assign rd_ent    = seg_t'(ram_rdata);
  assign ram_wdata = SEG_W'(wr_ent);

  // streaming read engine
  always_comb begin
    unique case (state_r)
      S_SCAN, S_MERGE, S_SHDN: rd_issue = (rc_r < lim_r);
      S_SHUP:                  rd_issue = (rc_r > lim_r);
      default:                 rd_issue = 1'b0;
    endcase
  end

  assign rd_ptr     = (state_r == S_SHUP) ? rc_r - 1'b1 : rc_r;
  assign ram_raddr  = rd_ptr[IDXW-1:0];
  assign stream_fin = !rd_issue && !dv_r;

  // merge arithmetic
  assign both_free = (pend_r.owner == '0) && (rd_ent.owner == '0);
  assign msum      = {1'b0, pend_r.size} + {1'b0, rd_ent.size};
  assign msat      = msum[KB_W] ? KB_MASK : msum[KB_W-1:0];
  assign pf_size   = (pend_r.owner == '0) ? pend_r.size : '0;
  assign tot_fin   = tot_r + TOTW'(pf_size);
  assign max_fin   = (pf_size > max_r) ? pf_size : max_r;
  assign tot_clip  = (tot_fin > TOTW'(KB_MASK)) ? KB_MASK : tot_fin[KB_W-1:0];

  assign key_a   = (in_r.op == OP_MOVE) ? in_r.src_handle : in_r.handle;
  assign newh    = top_r + 1'b1;
  assign hl      = 16'hFFFF - top_handle_r;
  assign cnt_dec = (a20cnt_r != '0) ? a20cnt_r - 1'b1 : a20cnt_r;

  assign exec_scan = (in_r.op == OP_ALLOC) || (in_r.op == OP_FREE) ||
                     (in_r.op == OP_LOCK) || (in_r.op == OP_UNLOCK) ||
                     (in_r.op == OP_INFO) || (in_r.op == OP_REALLOC) ||
                     ((in_r.op == OP_MOVE) && !in_r.move_length[0]);

  assign alloc_split = (bent_r.size > req_r) && (used_r < MAX_CNT);
  assign grow_sum    = {1'b0, fa_ent_r.size} + {1'b0, nxt_ent_r.size};
  assign grow_d      = req_r - fa_ent_r.size;
  assign grow_ok     = nxt_v_r && (nxt_ent_r.owner == '0) && (grow_sum >= {1'b0, req_r});

  // move address resolution
  assign s_conv = conv_addr(in_r.src_offset, a20l_r);
  assign d_conv = conv_addr(in_r.dst_offset, a20l_r);
  assign s_lin  = POOL_BASE + {fa_ent_r.offset, 10'b0} + in_r.src_offset;
  assign d_lin  = POOL_BASE + {fb_ent_r.offset, 10'b0} + in_r.dst_offset;
  assign s_bad  = ({1'b0, in_r.src_offset} + {1'b0, in_r.move_length}) >
                  {1'b0, fa_ent_r.size, 10'b0};
  assign d_bad  = ({1'b0, in_r.dst_offset} + {1'b0, in_r.move_length}) >
                  {1'b0, fb_ent_r.size, 10'b0};
  assign mv_sl  = (in_r.src_handle == '0) ? s_conv : s_lin;
  assign mv_dl  = (in_r.dst_handle == '0) ? d_conv : d_lin;
  assign ovl    = (mv_sl_r > mv_dl_r) &&
                  ({1'b0, mv_sl_r} < ({1'b0, mv_dl_r} + {1'b0, in_r.move_length}));

  always_comb begin
    if ((in_r.src_handle != '0) && !fa_r) begin
      mv_st = ST_BAD_SRC_H;
    end else if ((in_r.src_handle != '0) && s_bad) begin
      mv_st = ST_BAD_SRC_O;
    end else if ((in_r.dst_handle != '0) && !fb_r) begin
      mv_st = ST_BAD_DST_H;
    end else if ((in_r.dst_handle != '0) && d_bad) begin
      mv_st = ST_BAD_DST_O;
    end else begin
      mv_st = ST_OK;
    end
  end

  // decision after a table lookup
  always_comb begin
    p_next   = S_DONE;
    p_st     = ST_OK;
    p_res    = res_r;
    p_wa_idx = '0;
    p_wa_ent = fa_ent_r;
    p_wb_idx = fa_idx_r;
    p_wb_ent = fa_ent_r;
    p_used   = used_r;
    p_rc     = rc_r;
    p_lim    = lim_r;
    p_top_we = 1'b0;
    p_top    = top_r;
    unique case (in_r.op)
      OP_ALLOC: begin
        p_top_we = 1'b1;
        if (top_r == 16'hFFFF) begin
          p_st = ST_NO_HANDLE;
        end else if (!bf_r) begin
          p_st = ST_NO_MEM;
        end else begin
          p_top            = newh;
          p_res.handle_out = newh;
          p_wb_idx         = bidx_r;
          p_wb_ent         = bent_r;
          p_wb_ent.owner   = newh;
          if (alloc_split) begin
            p_wa_idx       = bidx_r + 1'b1;
            p_wa_ent       = '{offset: bent_r.offset + req_r, size: bent_r.size - req_r,
                               owner: '0, locks: '0};
            p_wb_ent.size  = req_r;
            p_used         = used_r + 1'b1;
            p_rc           = used_r;
            p_lim          = CNTW'(bidx_r) + 1'b1;
            p_next         = S_SHUP;
          end else begin
            p_next = S_WB;
          end
        end
      end
      OP_FREE: begin
        if (!fa_r) begin
          p_st = ST_BAD_HANDLE;
        end else if (fa_ent_r.locks != '0) begin
          p_st = ST_LOCKED;
        end else begin
          p_wb_ent.owner = '0;
          p_next         = S_WB;
        end
      end
      OP_LOCK: begin
        if (!fa_r) begin
          p_st = ST_BAD_HANDLE;
        end else begin
          p_res.block_address = POOL_BASE + {fa_ent_r.offset, 10'b0};
          if (fa_ent_r.locks == 8'hFF) begin
            p_st             = ST_LOCK_OVF;
            p_res.lock_count = fa_ent_r.locks;
          end else begin
            p_wb_ent.locks   = fa_ent_r.locks + 1'b1;
            p_res.lock_count = fa_ent_r.locks + 1'b1;
            p_next           = S_WB;
          end
        end
      end
      OP_UNLOCK: begin
        if (!fa_r) begin
          p_st = ST_BAD_HANDLE;
        end else if (fa_ent_r.locks == '0) begin
          p_st             = ST_NOT_LOCKED;
          p_res.lock_count = '0;
        end else begin
          p_wb_ent.locks   = fa_ent_r.locks - 1'b1;
          p_res.lock_count = fa_ent_r.locks - 1'b1;
          p_next           = S_WB;
        end
      end
      OP_INFO: begin
        if (!fa_r) begin
          p_st = ST_BAD_HANDLE;
        end else begin
          p_res.handles_left  = (!in_r.wide && (hl > 16'h00FF)) ? 16'h00FF : hl;
          p_res.block_size_kb = (!in_r.wide && (fa_ent_r.size > 22'h00FFFF)) ?
                                22'h00FFFF : fa_ent_r.size;
          p_res.lock_count    = fa_ent_r.locks;
        end
      end
      OP_REALLOC: begin
        if (!fa_r) begin
          p_st = ST_BAD_HANDLE;
        end else if (!ph_r) begin
          if (fa_ent_r.locks != '0) begin
            p_st = ST_LOCKED;
          end else if (fa_ent_r.size > req_r) begin
            if (used_r >= MAX_CNT) begin
              p_st = ST_NO_MEM;
            end else begin
              p_wa_idx      = fa_idx_r + 1'b1;
              p_wa_ent      = '{offset: fa_ent_r.offset + req_r,
                                size: fa_ent_r.size - req_r, owner: '0, locks: '0};
              p_wb_ent.size = req_r;
              p_used        = used_r + 1'b1;
              p_rc          = used_r;
              p_lim         = CNTW'(fa_idx_r) + 1'b1;
              p_next        = S_SHUP;
            end
          end else if (fa_ent_r.size < req_r) begin
            p_rc   = '0;
            p_lim  = used_r;
            p_next = S_MERGE;
          end
        end else if (grow_ok) begin
          p_wb_ent.size = req_r;
          if (nxt_ent_r.size == grow_d) begin
            p_used = used_r - 1'b1;
            p_rc   = CNTW'(fa_idx_r) + 2'd2;
            p_lim  = used_r;
            p_next = S_SHDN;
          end else begin
            p_wa_idx        = fa_idx_r + 1'b1;
            p_wa_ent        = nxt_ent_r;
            p_wa_ent.size   = nxt_ent_r.size - grow_d;
            p_wa_ent.offset = nxt_ent_r.offset + grow_d;
            p_next          = S_WA;
          end
        end else begin
          p_st = ST_NO_MEM;
        end
      end
      OP_MOVE: p_next = S_MV;
      default: p_next = S_DONE;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid && in_ready) state_nxt = S_EXEC;
      S_EXEC: begin
        if (exec_scan) begin
          state_nxt = S_SCAN;
        end else if (in_r.op == OP_QUERY_FREE) begin
          state_nxt = S_MERGE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN:   if (stream_fin) state_nxt = S_POST;
      S_POST:   state_nxt = p_next;
      S_MERGE:  if (stream_fin) state_nxt = S_MFLUSH;
      S_MFLUSH: state_nxt = (in_r.op == OP_QUERY_FREE) ? S_DONE : S_SCAN;
      S_SHUP:   if (stream_fin) state_nxt = S_WA;
      S_SHDN:   if (stream_fin) state_nxt = S_WB;
      S_WA:     state_nxt = S_WB;
      S_WB:     state_nxt = S_DONE;
      S_MV:     state_nxt = S_MV2;
      S_MV2:    state_nxt = S_DONE;
      S_DONE:   if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // handshake and table write port
  always_comb begin
    in_ready  = (state_r == S_IDLE) && !init_pend_r;
    ram_we    = 1'b0;
    ram_waddr = '0;
    wr_ent    = rd_ent;
    unique case (state_r)
      S_IDLE: begin
        ram_we = init_pend_r;
        wr_ent = '{offset: '0, size: cfg_pool_r, owner: '0, locks: '0};
      end
      S_MERGE: begin
        ram_we    = dv_r && (di_r != '0) && !both_free;
        ram_waddr = wp_r;
        wr_ent    = pend_r;
      end
      S_MFLUSH: begin
        ram_we    = 1'b1;
        ram_waddr = wp_r;
        wr_ent    = pend_r;
      end
      S_SHUP: begin
        ram_we    = dv_r;
        ram_waddr = di_r + 1'b1;
      end
      S_SHDN: begin
        ram_we    = dv_r;
        ram_waddr = di_r - 1'b1;
      end
      S_WA: begin
        ram_we    = 1'b1;
        ram_waddr = wa_idx_r;
        wr_ent    = wa_ent_r;
      end
      S_WB: begin
        ram_we    = 1'b1;
        ram_waddr = wb_idx_r;
        wr_ent    = wb_ent_r;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    fin        = res_r;
    fin.ok     = okset_r ? res_r.ok : (st_r == ST_OK);
    fin.status = st_r;
    fin.a20_on = a20l_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      init_pend_r  <= 1'b1;
      used_r       <= CNTW'(1);
      top_handle_r <= '0;
      hma_r        <= 1'b0;
      a20g_r       <= 1'b0;
      a20l_r       <= 1'b0;
      a20cnt_r     <= '0;
      cfg_pool_r   <= POOL_KB_RESET;
      dv_r         <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dv_r    <= rd_issue;
      di_r    <= ram_raddr;
      if (rd_issue) begin
        rc_r <= (state_r == S_SHUP) ? rc_r - 1'b1 : rc_r + 1'b1;
      end

      if ((state_r == S_IDLE) && init_pend_r &&
          !(cfg_we && (cfg_index == CFG_POOL_KB))) begin
        init_pend_r <= 1'b0;
      end

      if (in_valid && in_ready) begin
        in_r    <= in_data;
        req_r   <= in_data.wide ? in_data.size_kb : {6'b0, in_data.size_kb[15:0]};
        res_r   <= '0;
        st_r    <= ST_OK;
        okset_r <= 1'b0;
        ph_r    <= 1'b0;
      end

      // lookup pass set-up
      if ((state_nxt == S_SCAN) && (state_r != S_SCAN)) begin
        rc_r    <= '0;
        lim_r   <= (state_r == S_MFLUSH) ? CNTW'(wp_r) + 1'b1 : used_r;
        fa_r    <= 1'b0;
        fb_r    <= 1'b0;
        bf_r    <= 1'b0;
        nxt_v_r <= 1'b0;
        grab_r  <= 1'b0;
        top_r   <= '0;
      end
      if ((state_nxt == S_MERGE) && (state_r != S_MERGE)) begin
        wp_r  <= '0;
        tot_r <= '0;
        max_r <= '0;
        top_r <= '0;
      end
      if ((state_nxt == S_MERGE) && (state_r == S_EXEC)) begin
        rc_r  <= '0;
        lim_r <= used_r;
      end

      unique case (state_r)
        S_EXEC: begin
          unique case (in_r.op)
            OP_REQ_HMA: begin
              if (hma_r) st_r <= ST_HMA_USED;
              else hma_r <= 1'b1;
            end
            OP_REL_HMA: begin
              if (hma_r) hma_r <= 1'b0;
              else st_r <= ST_HMA_FREE;
            end
            OP_GLOBAL_ON: begin
              a20g_r <= 1'b1;
              a20l_r <= 1'b1;
            end
            OP_GLOBAL_OFF: begin
              a20g_r <= 1'b0;
              if (a20cnt_r == '0) begin
                a20l_r <= 1'b0;
              end else begin
                a20l_r <= 1'b1;
                st_r   <= ST_A20_STILL;
              end
            end
            OP_LOCAL_ON: begin
              if (a20cnt_r > 17'h0FFFF) begin
                st_r <= ST_A20_ERR;
              end else begin
                a20cnt_r <= a20cnt_r + 1'b1;
                a20l_r   <= 1'b1;
              end
            end
            OP_LOCAL_OFF: begin
              a20cnt_r <= cnt_dec;
              if (!a20g_r && (cnt_dec == '0)) begin
                a20l_r <= 1'b0;
              end else begin
                a20l_r <= 1'b1;
                st_r   <= ST_A20_STILL;
              end
            end
            OP_QUERY_A20: begin
              res_r.ok <= a20l_r;
              okset_r  <= 1'b1;
            end
            OP_QUERY_FREE, OP_ALLOC, OP_FREE, OP_LOCK, OP_UNLOCK, OP_INFO,
            OP_REALLOC: st_r <= ST_OK;
            OP_MOVE: begin
              if (in_r.move_length[0]) st_r <= ST_BAD_LEN;
            end
            OP_REQ_UMB:                 st_r <= ST_UMB_NA;
            OP_REL_UMB, OP_REALLOC_UMB: st_r <= ST_UMB_BAD;
            default:                    st_r <= ST_UNIMPL;
          endcase
        end
        S_SCAN: begin
          if (dv_r) begin
            if (rd_ent.owner > top_r) top_r <= rd_ent.owner;
            if (!fa_r && (key_a != '0) && (rd_ent.owner == key_a)) begin
              fa_r     <= 1'b1;
              fa_idx_r <= di_r;
              fa_ent_r <= rd_ent;
              grab_r   <= 1'b1;
            end else if (grab_r) begin
              nxt_v_r   <= 1'b1;
              nxt_ent_r <= rd_ent;
              grab_r    <= 1'b0;
            end
            if (!fb_r && (in_r.dst_handle != '0) && (rd_ent.owner == in_r.dst_handle)) begin
              fb_r     <= 1'b1;
              fb_ent_r <= rd_ent;
            end
            if ((rd_ent.owner == '0) && (rd_ent.size >= req_r) &&
                (!bf_r || (rd_ent.size < bent_r.size))) begin
              bf_r   <= 1'b1;
              bidx_r <= di_r;
              bent_r <= rd_ent;
            end
          end
        end
        S_POST: begin
          st_r     <= p_st;
          res_r    <= p_res;
          wa_idx_r <= p_wa_idx;
          wa_ent_r <= p_wa_ent;
          wb_idx_r <= p_wb_idx;
          wb_ent_r <= p_wb_ent;
          used_r   <= p_used;
          rc_r     <= p_rc;
          lim_r    <= p_lim;
          if (p_top_we) top_handle_r <= p_top;
        end
        S_MERGE: begin
          if (dv_r) begin
            if (rd_ent.owner > top_r) top_r <= rd_ent.owner;
            if (di_r == '0) begin
              pend_r <= rd_ent;
            end else if (both_free) begin
              pend_r.size <= msat;
            end else begin
              if (pend_r.owner == '0) begin
                tot_r <= tot_r + TOTW'(pend_r.size);
                if (pend_r.size > max_r) max_r <= pend_r.size;
              end
              wp_r   <= wp_r + 1'b1;
              pend_r <= rd_ent;
            end
          end
        end
        S_MFLUSH: begin
          used_r       <= CNTW'(wp_r) + 1'b1;
          top_handle_r <= top_r;
          ph_r         <= 1'b1;
          if (in_r.op == OP_QUERY_FREE) begin
            if (tot_clip == '0) st_r <= ST_NO_MEM;
            res_r.free_largest_kb <= (!in_r.wide && (max_fin > 22'h00FFFF)) ?
                                     22'h00FFFF : max_fin;
            res_r.free_total_kb   <= (!in_r.wide && (tot_clip > 22'h00FFFF)) ?
                                     22'h00FFFF : tot_clip;
          end
        end
        S_MV: begin
          st_r    <= mv_st;
          mv_sl_r <= mv_sl;
          mv_dl_r <= mv_dl;
        end
        S_MV2: begin
          if (st_r == ST_OK) begin
            if (ovl) begin
              st_r <= ST_OVERLAP;
            end else begin
              res_r.src_linear <= mv_sl_r;
              res_r.dst_linear <= mv_dl_r;
            end
          end
        end
        default: begin
        end
      endcase

      if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
        out_data_r  <= fin;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        if (cfg_index == CFG_POOL_KB) begin
          cfg_pool_r   <= cfg_data;
          init_pend_r  <= 1'b1;
          used_r       <= CNTW'(1);
          top_handle_r <= '0;
        end else begin
          a20g_r <= cfg_data[0];
          a20l_r <= cfg_data[0];
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // streaming passes never read and write one entry in the same cycle
  a_no_collision : assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && rd_issue) |-> (ram_waddr != ram_raddr))
    else $error("table read and write collide");

  a_used_range : assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != '0) && (used_r <= MAX_CNT))
    else $error("segment count out of range");

  a_beat_starts : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted beat not started");

  a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside completion");

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the extended memory block manager. Calls are sent as beats on
// the input channel, a local model of the segment table, HMA and A20 state
// predicts every result, and each result beat is compared field by field in
// order. Directed tests cover the A20 and HMA calls, allocation, locking,
// moves, reallocation and the table and lock limits; random traffic runs
// under several pool sizes with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top import emb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEG = 64;
  localparam logic [31:0] BASE = 32'h0011_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [KB_W-1:0] cfg_data = '0;

  int errors = 0;
  bit quiet = 1'b0;
  out_t pending_q[$];

  // model state
  logic [21:0] m_off[NSEG];
  logic [21:0] m_size[NSEG];
  logic [15:0] m_owner[NSEG];
  logic [7:0] m_locks[NSEG];
  int unsigned m_used;
  logic [15:0] m_top;
  bit m_hma;
  bit m_a20g;
  bit m_a20;
  logic [16:0] m_local;
  logic [21:0] m_pool;

  extended_memory_block_manager u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void pool_rebuild();
    for (int i = 0; i < NSEG; i++) begin
      m_off[i] = '0; m_size[i] = '0; m_owner[i] = '0; m_locks[i] = '0;
    end
    m_size[0] = m_pool;
    m_used = 1;
    m_top = '0;
  endfunction

  function automatic int seg_find(logic [15:0] h);
    if (h == 0) return -1;
    for (int i = 0; i < m_used; i++) if (m_owner[i] == h) return i;
    return -1;
  endfunction

  function automatic void seg_insert(int i, logic [31:0] off, logic [31:0] sz);
    for (int j = m_used; j > i + 1; j--) begin
      m_off[j] = m_off[j-1]; m_size[j] = m_size[j-1];
      m_owner[j] = m_owner[j-1]; m_locks[j] = m_locks[j-1];
    end
    m_off[i+1] = off[21:0]; m_size[i+1] = sz[21:0];
    m_owner[i+1] = '0; m_locks[i+1] = '0;
    m_used++;
  endfunction

  function automatic void seg_remove(int i);
    for (int j = i; j + 1 < m_used; j++) begin
      m_off[j] = m_off[j+1]; m_size[j] = m_size[j+1];
      m_owner[j] = m_owner[j+1]; m_locks[j] = m_locks[j+1];
    end
    m_used--;
  endfunction

  function automatic void seg_merge(output logic [31:0] total, output logic [31:0] largest);
    int i;
    logic [31:0] s;
    logic [15:0] top;
    i = 0; total = 0; largest = 0; top = 0;
    while (i < m_used) begin
      if (m_owner[i] == 0 && i + 1 < m_used && m_owner[i+1] == 0) begin
        s = m_size[i] + m_size[i+1];
        m_size[i] = (s > KB_MASK) ? KB_MASK : s[21:0];
        seg_remove(i + 1);
      end else begin
        if (m_owner[i] == 0) begin
          total += m_size[i];
          if (m_size[i] > largest) largest = m_size[i];
        end
        if (m_owner[i] > top) top = m_owner[i];
        i++;
      end
    end
    m_top = top;
    if (total > KB_MASK) total = KB_MASK;
  endfunction

  function automatic int addr_resolve(logic [15:0] h, logic [31:0] v, logic [31:0] len,
                                      output logic [31:0] lin);
    int k;
    logic [31:0] a;
    lin = 0;
    if (h == 0) begin
      a = {12'd0, v[31:16], 4'd0} + {16'd0, v[15:0]};
      if (!m_a20) a &= 32'h000F_FFFF;
      lin = a;
      return 0;
    end
    k = seg_find(h);
    if (k < 0) return 1;
    if ({32'd0, v} + {32'd0, len} > {42'd0, m_size[k]} * 64'd1024) return 2;
    lin = BASE + {10'd0, m_off[k]} * 32'd1024 + v;
    return 0;
  endfunction

  function automatic out_t predict_call(in_t x);
    out_t r;
    logic [4:0] st;
    logic [31:0] req, t, m, sl, dl, d;
    int k, best, e, n;
    logic [15:0] top;
    bit okset;
    r = '0; st = ST_OK; okset = 0;
    req = {10'd0, x.size_kb};
    if (!x.wide) req &= 32'hFFFF;
    case (x.op)
      OP_REQ_HMA: if (m_hma) st = ST_HMA_USED; else m_hma = 1;
      OP_REL_HMA: if (m_hma) m_hma = 0; else st = ST_HMA_FREE;
      OP_GLOBAL_ON: begin m_a20g = 1; m_a20 = 1; end
      OP_GLOBAL_OFF: begin
        m_a20g = 0;
        if (m_local == 0) m_a20 = 0;
        else begin m_a20 = 1; st = ST_A20_STILL; end
      end
      OP_LOCAL_ON: if (m_local > 17'hFFFF) st = ST_A20_ERR;
                   else begin m_local++; m_a20 = 1; end
      OP_LOCAL_OFF: begin
        if (m_local > 0) m_local--;
        if (!m_a20g && m_local == 0) m_a20 = 0;
        else begin m_a20 = 1; st = ST_A20_STILL; end
      end
      OP_QUERY_A20: begin r.ok = m_a20; okset = 1; end
      OP_QUERY_FREE: begin
        seg_merge(t, m);
        if (t == 0) st = ST_NO_MEM;
        r.free_largest_kb = (!x.wide && m > 32'hFFFF) ? 22'hFFFF : m[21:0];
        r.free_total_kb = (!x.wide && t > 32'hFFFF) ? 22'hFFFF : t[21:0];
      end
      OP_ALLOC: begin
        best = -1; top = 0;
        for (int i = 0; i < m_used; i++) begin
          if (m_owner[i] == 0 && m_size[i] >= req && (best < 0 || m_size[i] < m_size[best]))
            best = i;
          if (m_owner[i] > top) top = m_owner[i];
        end
        m_top = top;
        if (m_top == 16'hFFFF) st = ST_NO_HANDLE;
        else if (best < 0) st = ST_NO_MEM;
        else begin
          if (m_size[best] > req && m_used < NSEG) begin
            seg_insert(best, m_off[best] + req, m_size[best] - req);
            m_size[best] = req[21:0];
          end
          m_top++;
          m_owner[best] = m_top;
          r.handle_out = m_top;
        end
      end
      OP_FREE: begin
        k = seg_find(x.handle);
        if (k < 0) st = ST_BAD_HANDLE;
        else if (m_locks[k] != 0) st = ST_LOCKED;
        else m_owner[k] = 0;
      end
      OP_MOVE: begin
        if (x.move_length[0]) st = ST_BAD_LEN;
        else begin
          e = addr_resolve(x.src_handle, x.src_offset, x.move_length, sl);
          if (e != 0) st = (e == 1) ? ST_BAD_SRC_H : ST_BAD_SRC_O;
          else begin
            e = addr_resolve(x.dst_handle, x.dst_offset, x.move_length, dl);
            if (e != 0) st = (e == 1) ? ST_BAD_DST_H : ST_BAD_DST_O;
            else if (sl > dl && {32'd0, sl} < {32'd0, dl} + {32'd0, x.move_length})
              st = ST_OVERLAP;
            else begin r.src_linear = sl; r.dst_linear = dl; end
          end
        end
      end
      OP_LOCK: begin
        k = seg_find(x.handle);
        if (k < 0) st = ST_BAD_HANDLE;
        else begin
          r.block_address = BASE + {10'd0, m_off[k]} * 32'd1024;
          if (m_locks[k] == 8'hFF) st = ST_LOCK_OVF; else m_locks[k]++;
          r.lock_count = m_locks[k];
        end
      end
      OP_UNLOCK: begin
        k = seg_find(x.handle);
        if (k < 0) st = ST_BAD_HANDLE;
        else begin
          if (m_locks[k] == 0) st = ST_NOT_LOCKED; else m_locks[k]--;
          r.lock_count = m_locks[k];
        end
      end
      OP_INFO: begin
        k = seg_find(x.handle);
        if (k < 0) st = ST_BAD_HANDLE;
        else begin
          t = 32'hFFFF - m_top;
          r.handles_left = (!x.wide && t > 32'hFF) ? 16'hFF : t[15:0];
          r.block_size_kb = (!x.wide && m_size[k] > 22'hFFFF) ? 22'hFFFF : m_size[k];
          r.lock_count = m_locks[k];
        end
      end
      OP_REALLOC: begin
        k = seg_find(x.handle);
        if (k < 0) st = ST_BAD_HANDLE;
        else if (m_locks[k] != 0) st = ST_LOCKED;
        else if (m_size[k] > req) begin
          if (m_used >= NSEG) st = ST_NO_MEM;
          else begin
            seg_insert(k, m_off[k] + req, m_size[k] - req);
            m_size[k] = req[21:0];
          end
        end else if (m_size[k] < req) begin
          seg_merge(t, m);
          k = seg_find(x.handle);
          n = k + 1;
          if (n < m_used && m_owner[n] == 0 && m_size[k] + m_size[n] >= req) begin
            d = req - m_size[k];
            if (m_size[n] == d) seg_remove(n);
            else begin
              m_size[n] = m_size[n] - d[21:0];
              m_off[n] = m_off[n] + d[21:0];
            end
            m_size[k] = req[21:0];
          end else st = ST_NO_MEM;
        end
      end
      OP_REQ_UMB: st = ST_UMB_NA;
      OP_REL_UMB, OP_REALLOC_UMB: st = ST_UMB_BAD;
      default: st = ST_UNIMPL;
    endcase
    if (!okset) r.ok = (st == ST_OK);
    r.status = st;
    r.a20_on = m_a20;
    return r;
  endfunction

  task automatic field_check(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // prediction on each accepted call, comparison on each result beat
  always @(posedge clk) begin
    out_t w;
    if (rst_n && in_valid && in_ready) pending_q.push_back(predict_call(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $error("result beat with no call outstanding");
        errors++;
      end else begin
        w = pending_q.pop_front();
        field_check("ok", w.ok, out_data.ok);
        field_check("status", w.status, out_data.status);
        field_check("free_largest_kb", w.free_largest_kb, out_data.free_largest_kb);
        field_check("free_total_kb", w.free_total_kb, out_data.free_total_kb);
        field_check("handle_out", w.handle_out, out_data.handle_out);
        field_check("block_address", w.block_address, out_data.block_address);
        field_check("lock_count", w.lock_count, out_data.lock_count);
        field_check("handles_left", w.handles_left, out_data.handles_left);
        field_check("block_size_kb", w.block_size_kb, out_data.block_size_kb);
        field_check("src_linear", w.src_linear, out_data.src_linear);
        field_check("dst_linear", w.dst_linear, out_data.dst_linear);
        field_check("a20_on", w.a20_on, out_data.a20_on);
      end
    end
  end

  always @(negedge clk) out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 11);

  // valid stays high after a beat until the next idle cycle or drain
  task automatic send_call(in_t x);
    while (!quiet && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [21:0] val);
    drain();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POOL_KB) begin m_pool = val; pool_rebuild(); end
    else begin m_a20g = val[0]; m_a20 = val[0]; end
    repeat (2) @(negedge clk);
  endtask

  function automatic in_t mk(logic [4:0] op, logic [15:0] h = 0, logic [21:0] sz = 0,
                             bit wide = 0);
    in_t x;
    x = '0; x.op = op; x.handle = h; x.size_kb = sz; x.wide = wide;
    return x;
  endfunction

  function automatic logic [15:0] any_handle();
    int live[$];
    for (int i = 0; i < m_used; i++) if (m_owner[i] != 0) live.push_back(i);
    if (live.size() == 0 || $urandom_range(0, 9) == 0) return 16'($urandom_range(0, 70));
    return m_owner[live[$urandom_range(0, live.size() - 1)]];
  endfunction

  function automatic logic [31:0] blk_offset(logic [15:0] h);
    int k;
    k = seg_find(h);
    if (k < 0 || m_size[k] == 0 || $urandom_range(0, 7) == 0) return $urandom;
    return $urandom_range(0, m_size[k] * 1024 - 1) & ~32'd1;
  endfunction

  function automatic in_t mk_move();
    in_t x;
    x = mk(OP_MOVE);
    x.move_length = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom_range(0, 4096) & ~1);
    x.src_handle = ($urandom_range(0, 3) == 0) ? 16'd0 : any_handle();
    x.dst_handle = ($urandom_range(0, 3) == 0) ? 16'd0 : any_handle();
    x.src_offset = (x.src_handle == 0) ? $urandom : blk_offset(x.src_handle);
    x.dst_offset = (x.dst_handle == 0) ? $urandom : blk_offset(x.dst_handle);
    return x;
  endfunction

  task automatic test_a20_hma();
    send_call(mk(OP_QUERY_A20));
    send_call(mk(OP_REQ_HMA)); send_call(mk(OP_REQ_HMA));
    send_call(mk(OP_REL_HMA)); send_call(mk(OP_REL_HMA));
    send_call(mk(OP_LOCAL_ON)); send_call(mk(OP_GLOBAL_OFF));
    send_call(mk(OP_LOCAL_OFF)); send_call(mk(OP_LOCAL_OFF));
    send_call(mk(OP_GLOBAL_ON)); send_call(mk(OP_LOCAL_OFF));
    send_call(mk(OP_QUERY_A20)); send_call(mk(OP_GLOBAL_OFF));
    send_call(mk(OP_REQ_UMB)); send_call(mk(OP_REL_UMB));
    send_call(mk(OP_REALLOC_UMB)); send_call(mk(5'd31));
  endtask

  task automatic test_blocks();
    in_t x;
    send_call(mk(OP_QUERY_FREE)); send_call(mk(OP_QUERY_FREE, 0, 0, 1));
    send_call(mk(OP_ALLOC, 0, 22'h3FFFFF)); send_call(mk(OP_ALLOC, 0, 22'h3FFFFF, 1));
    send_call(mk(OP_ALLOC, 0, 0)); send_call(mk(OP_ALLOC, 0, 100));
    send_call(mk(OP_ALLOC, 0, 50)); send_call(mk(OP_FREE, 0));
    send_call(mk(OP_LOCK, 2)); send_call(mk(OP_FREE, 2)); send_call(mk(OP_REALLOC, 2, 10));
    send_call(mk(OP_UNLOCK, 2)); send_call(mk(OP_UNLOCK, 2));
    send_call(mk(OP_INFO, 2)); send_call(mk(OP_INFO, 3, 0, 1));
    send_call(mk(OP_REALLOC, 2, 40)); send_call(mk(OP_REALLOC, 2, 100));
    send_call(mk(OP_REALLOC, 2, 100)); send_call(mk(OP_REALLOC, 3, 22'h3FFFFF, 1));
    send_call(mk(OP_FREE, 1)); send_call(mk(OP_FREE, 9));
    x = mk(OP_MOVE); x.move_length = 1; send_call(x);
    x.move_length = 32'hFFFF_FFFE; x.src_handle = 3; send_call(x);
    x.move_length = 64; x.src_handle = 3; x.src_offset = 256; x.dst_handle = 3;
    x.dst_offset = 200; send_call(x);
    x.src_handle = 0; x.src_offset = 32'hFFFF_FFFF; x.dst_handle = 0; x.dst_offset = 0;
    send_call(x);
    x.src_handle = 77; send_call(x); x.src_handle = 0; x.dst_handle = 77; send_call(x);
    drain();
  endtask

  task automatic test_lock_limit();
    send_call(mk(OP_ALLOC, 0, 1));
    drain();
    for (int i = 0; i < 257; i++) send_call(mk(OP_LOCK, m_top));
    send_call(mk(OP_INFO, m_top, 0, 1));
  endtask

  task automatic test_table_full();
    for (int i = 0; i < 70; i++) send_call(mk(OP_ALLOC, 0, 2));
    drain();
    send_call(mk(OP_REALLOC, 5, 1));
    send_call(mk(OP_QUERY_FREE, 0, 0, 1));
  endtask

  task automatic test_random(int count);
    in_t x;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        x = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        if (x.op inside {OP_FREE, OP_LOCK, OP_UNLOCK, OP_INFO, OP_REALLOC} &&
            $urandom_range(0, 1)) x.handle = any_handle();
      end else if (r < 24) x = mk(OP_ALLOC, 0, 22'($urandom_range(0, 300)));
      else if (r < 34) x = mk(OP_FREE, any_handle());
      else if (r < 44) x = mk(OP_LOCK, any_handle());
      else if (r < 52) x = mk(OP_UNLOCK, any_handle());
      else if (r < 58) x = mk(OP_INFO, any_handle(), 0, $urandom_range(0, 1));
      else if (r < 70) x = mk(OP_REALLOC, any_handle(), 22'($urandom_range(0, 400)));
      else if (r < 84) x = mk_move();
      else if (r < 90) x = mk(OP_QUERY_FREE, 0, 0, $urandom_range(0, 1));
      else x = mk(5'($urandom_range(0, 6)));
      if (r >= 6 && $urandom_range(0, 15) == 0) begin
        x.wide = 1; x.size_kb = 22'($urandom);
      end
      if (i == count / 2) quiet = 1'b1;
      if (i == count / 2 + 60) quiet = 1'b0;
      if (i == count / 3) drain();
      send_call(x);
    end
    quiet = 1'b0;
  endtask

  initial begin
    m_pool = POOL_KB_RESET; pool_rebuild();
    m_hma = 0; m_a20g = 0; m_a20 = 0; m_local = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_a20_hma();
    test_blocks();
    test_lock_limit();
    cfg_write(CFG_POOL_KB, 22'd600);
    cfg_write(CFG_A20, 1'b1);
    test_random(120);
    test_table_full();
    cfg_write(CFG_POOL_KB, 22'h3FFFFF);
    cfg_write(CFG_A20, 1'b0);
    test_blocks();
    test_random(80);
    cfg_write(CFG_POOL_KB, 22'd0);
    send_call(mk(OP_QUERY_FREE)); send_call(mk(OP_ALLOC, 0, 0)); send_call(mk(OP_ALLOC, 0, 1));
    cfg_write(CFG_POOL_KB, 22'd2000);
    test_random(120);
    drain();
    repeat (300) @(negedge clk);
    if (errors == 0 && pending_q.size() == 0)
      $display("extended_memory_block_manager regression: pass");
    else
      $display("extended_memory_block_manager regression: fail");
    $finish;
  end

  initial begin
    #400ms;
    $display("extended_memory_block_manager regression: fail");
    $finish;
  end

endmodule

[sim.f]
design/emb_pkg.sv
design/emb_ram.sv
design/extended_memory_block_manager.sv
verif/tb_top.sv
